// ===== design/xrs_pkg.sv =====
// shared types, constants and the xorshift step function for the random source
`default_nettype none
package xrs_pkg;

  localparam int unsigned STATE_W      = 64;
  localparam int unsigned FRAC_W       = 53;
  localparam int unsigned FRAC_SHIFT   = 11;
  localparam int unsigned DEF_WARMUP   = 8;
  localparam int unsigned DIV_CNT_W    = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(STATE_W - 1);
  localparam logic [STATE_W-1:0]   GOLDEN_SEED = 64'h9e37_79b9_7f4a_7c15;

  typedef enum logic [1:0] {
    OP_SEED  = 2'd0,
    OP_UNIT  = 2'd1,
    OP_RANGE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WARM,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic seed_load;
    logic step;
    logic warm_dec;
    logic range_prep;
    logic div_step;
    logic out_load;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic reversed;
    logic warm_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // one xorshift step with shifts 13, 7, 17
  function automatic logic [STATE_W-1:0] xs_step(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] a;
    logic [STATE_W-1:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 7);
    return b ^ (b << 17);
  endfunction

endpackage
`default_nettype wire

// ===== design/xrs_ctrl.sv =====
// controller state machine for the random source
`default_nettype none
module xrs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire xrs_pkg::dp_status_t dp_stat,
  output xrs_pkg::ctl_cmd_t      cmd,
  output logic                   in_stall
);
  import xrs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (dp_stat.op)
          OP_SEED:  state_next = ST_WARM;
          OP_UNIT:  state_next = ST_FINISH;
          OP_RANGE: state_next = dp_stat.reversed ? ST_FINISH : ST_DIVIDE;
          OP_NONE:  state_next = ST_FINISH;
          default:  state_next = ST_FINISH;
        endcase
      end
      ST_WARM: begin
        if (dp_stat.warm_done) state_next = ST_FINISH;
      end
      ST_DIVIDE: begin
        if (dp_stat.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (dp_stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_DISPATCH: begin
        cmd.seed_load  = (dp_stat.op == OP_SEED);
        cmd.step       = (dp_stat.op == OP_UNIT) ||
                         ((dp_stat.op == OP_RANGE) && !dp_stat.reversed);
        cmd.range_prep = (dp_stat.op == OP_RANGE) && !dp_stat.reversed;
      end
      ST_WARM: begin
        cmd.step     = !dp_stat.warm_done;
        cmd.warm_dec = !dp_stat.warm_done;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = dp_stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/xrs_dp.sv =====
// datapath: generator state, warm-up counter, bit-serial remainder unit, result register
`default_nettype none
module xrs_dp #(
  parameter int unsigned WARMUP_STEPS = xrs_pkg::DEF_WARMUP
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire xrs_pkg::ctl_cmd_t        cmd,
  output xrs_pkg::dp_status_t           dp_stat,
  input  wire logic [1:0]               func,
  input  wire logic [63:0]              seed_word,
  input  wire logic signed [63:0]       range_low,
  input  wire logic signed [63:0]       range_high,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [63:0]            int_value,
  output logic [xrs_pkg::FRAC_W-1:0]    unit_fraction,
  output logic                          status
);
  import xrs_pkg::*;

  localparam int unsigned WarmW = $clog2(WARMUP_STEPS + 2);

  op_t                  op_q;
  logic [STATE_W-1:0]   seed_q;
  logic [STATE_W-1:0]   lo_q;
  logic [STATE_W-1:0]   hi_q;
  logic [STATE_W-1:0]   gen_state;
  logic [STATE_W-1:0]   stepped;
  logic [WarmW-1:0]     warm_cnt;
  logic [STATE_W-1:0]   span;
  logic [STATE_W-1:0]   dividend;
  logic [STATE_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [STATE_W:0]     rem_shift;
  logic [STATE_W:0]     rem_sub;
  logic                 reversed;
  logic                 out_free;

  assign stepped   = xs_step(gen_state);
  assign reversed  = $signed(hi_q) < $signed(lo_q);
  assign out_free  = !out_valid || !out_stall;
  assign rem_shift = {rem, dividend[STATE_W-1]};
  assign rem_sub   = rem_shift - {1'b0, span};

  assign dp_stat.op        = op_q;
  assign dp_stat.reversed  = reversed;
  assign dp_stat.warm_done = (warm_cnt == '0);
  assign dp_stat.div_done  = (div_cnt == '0);
  assign dp_stat.out_free  = out_free;

  // request operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= op_t'(func);
      seed_q <= seed_word;
      lo_q   <= range_low;
      hi_q   <= range_high;
    end
  end

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= GOLDEN_SEED;
    end else if (cmd.seed_load) begin
      gen_state <= (seed_q != '0) ? seed_q : GOLDEN_SEED;
    end else if (cmd.step) begin
      gen_state <= stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      warm_cnt <= WarmW'(WARMUP_STEPS);
    end else if (cmd.warm_dec) begin
      warm_cnt <= warm_cnt - 1'b1;
    end
  end

  // restoring remainder, one dividend bit a cycle; a zero span leaves the raw state
  always_ff @(posedge clk) begin
    if (cmd.range_prep) begin
      span     <= hi_q - lo_q + 64'd1;
      dividend <= stepped;
      rem      <= '0;
      div_cnt  <= DIV_LAST;
    end else if (cmd.div_step) begin
      rem      <= rem_sub[STATE_W] ? rem_shift[STATE_W-1:0] : rem_sub[STATE_W-1:0];
      dividend <= {dividend[STATE_W-2:0], 1'b0};
      div_cnt  <= div_cnt - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      int_value     <= ((op_q == OP_RANGE) && !reversed) ? $signed(lo_q + rem) : '0;
      unit_fraction <= (op_q == OP_UNIT) ? gen_state[STATE_W-1:FRAC_SHIFT] : '0;
      status        <= (op_q == OP_RANGE) && reversed;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over an unread result");

  a_no_prep_reversed: assert property (@(posedge clk) disable iff (rst)
    cmd.range_prep |-> !reversed)
    else $error("division started on a reversed range");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (int_value == '0) && (unit_fraction == '0))
    else $error("error result carries data");

  a_reversed_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && (op_q == OP_RANGE) && reversed) |-> $stable(gen_state))
    else $error("state moved on a reversed range");

endmodule
`default_nettype wire

// ===== design/xorshift_random_source.sv =====
// top level of the xorshift random source: controller plus datapath
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------
//  in      | in_valid  | in_stall  | func, seed_word, range_low, range_high
//  out     | out_valid | out_stall | int_value, unit_fraction, status
//
// one request at a time; a seed request runs WARMUP_STEPS warm-up steps, a unit
// request steps the generator, a range request steps it and then runs the
// one-bit-a-cycle remainder loop, and a reversed range or unused code goes straight to finish
// reset loads the golden constant into the generator and empties the result register
// a waiting result sits in its own register, so the next request is taken meanwhile
// out_stall only holds the finish step until the result register frees up
`default_nettype none
module xorshift_random_source #(
  parameter int unsigned WARMUP_STEPS = xrs_pkg::DEF_WARMUP
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            func,
  input  wire logic [63:0]           seed_word,
  input  wire logic signed [63:0]    range_low,
  input  wire logic signed [63:0]    range_high,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [63:0]         int_value,
  output logic [xrs_pkg::FRAC_W-1:0] unit_fraction,
  output logic                       status
);
  import xrs_pkg::*;

  // command and status between the two halves
  ctl_cmd_t   cmd;
  dp_status_t dp_stat;

  // sequencer: idle, dispatch, warm-up or divide, finish
  xrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .dp_stat  (dp_stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // generator state, remainder unit and result register
  xrs_dp #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .dp_stat       (dp_stat),
    .func          (func),
    .seed_word     (seed_word),
    .range_low     (range_low),
    .range_high    (range_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .int_value     (int_value),
    .unit_fraction (unit_fraction),
    .status        (status)
  );

endmodule
`default_nettype wire
